### sv/free_list_slot_allocator_assert.svh
// Assertion macros shared by the free list slot allocator.
`ifndef FREE_LIST_SLOT_ALLOCATOR_ASSERT_SVH
`define FREE_LIST_SLOT_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FLS_ASSERT_NOW(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("free_list_slot_allocator: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define FLS_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("free_list_slot_allocator: next-cycle check failed");

`endif

### sv/fls_pkg.sv
// Types, codes and constants of the free list slot allocator.
package fls_pkg;

    localparam int FLS_POOL_SLOTS = 2048;

    // Request codes
    localparam logic [1:0] REQ_ALLOC    = 2'd0;
    localparam logic [1:0] REQ_FREE     = 2'd1;
    localparam logic [1:0] REQ_FREE_ALL = 2'd2;

    // Result status codes
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_EMPTY    = 2'd1;
    localparam logic [1:0] STATUS_BAD_FREE = 2'd2;

    typedef logic [10:0] t_slot_handle;

    typedef struct packed {
        logic [1:0]   req_type;
        t_slot_handle slot_in;
    } t_req_beat;

    typedef struct packed {
        t_slot_handle slot_out;
        logic [1:0]   status;
    } t_result_beat;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_ALLOC_WR,
        ST_FREE_CHK,
        ST_FREE_LINK1,
        ST_FREE_LINK2,
        ST_WALK
    } t_state;

    typedef enum logic [3:0] {
        DP_NONE,
        DP_INIT,
        DP_ALLOC_RD,
        DP_ALLOC_WR,
        DP_FREE_RD,
        DP_FREE_UNLINK,
        DP_FREE_LINK1,
        DP_FREE_LINK2,
        DP_WALK_HEAD,
        DP_WALK,
        DP_SPLICE
    } t_dp_op;

    typedef struct packed {
        t_dp_op     op;
        logic       emit;
        logic       grant;
        logic [1:0] code;
    } t_dp_cmd;

    typedef struct packed {
        logic init_last;
        logic free_empty;
        logic used_empty;
        logic slot_ok;
        logic rd_in_use;
        logic walk_end;
    } t_dp_status;

endpackage

### sv/fls_datapath.sv
// Link memories, list head/tail registers and result register of the allocator.
module fls_datapath
    import fls_pkg::*;
#(
    parameter int POOL_SLOTS = FLS_POOL_SLOTS
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_req_beat    i_req,
    input  t_dp_cmd      i_cmd,
    output t_dp_status   o_status,
    output t_result_beat o_result,
    output logic         o_done
);

    localparam int SLOT_W = $clog2(POOL_SLOTS);
    localparam int LINK_W = $clog2(POOL_SLOTS + 1);
    localparam logic [LINK_W-1:0] NIL = LINK_W'(POOL_SLOTS);
    localparam logic [SLOT_W-1:0] LAST = SLOT_W'(POOL_SLOTS - 1);

    logic [LINK_W-1:0] r_next_mem [POOL_SLOTS];
    logic [LINK_W-1:0] r_prev_mem [POOL_SLOTS];
    logic              r_use_mem  [POOL_SLOTS];

    logic [LINK_W-1:0] r_free_head, r_free_tail, r_used_head, r_used_tail;
    logic [LINK_W-1:0] n_free_head, n_free_tail, n_used_head, n_used_tail;
    logic [SLOT_W-1:0] r_slot, n_slot;
    logic [SLOT_W-1:0] r_init, n_init;
    logic [LINK_W-1:0] r_rd_next, r_rd_prev;
    logic              r_rd_use;
    logic              r_done;
    t_result_beat      r_result, n_result;

    logic              nx_we, nx_re, pv_we, us_we, fr_re;
    logic [SLOT_W-1:0] nx_wa, nx_ra, pv_wa, us_wa, slot_idx;
    logic [LINK_W-1:0] nx_wd, pv_wd, s_link;
    logic              us_wd;

    assign slot_idx = SLOT_W'(i_req.slot_in);
    assign s_link   = LINK_W'(r_slot);

    always_comb begin
        nx_we = 1'b0; nx_wa = '0; nx_wd = '0;
        pv_we = 1'b0; pv_wa = '0; pv_wd = '0;
        us_we = 1'b0; us_wa = '0; us_wd = 1'b0;
        nx_re = 1'b0; nx_ra = '0;
        fr_re = 1'b0;
        n_free_head = r_free_head;
        n_free_tail = r_free_tail;
        n_used_head = r_used_head;
        n_used_tail = r_used_tail;
        n_slot      = r_slot;
        n_init      = r_init;
        case (i_cmd.op)
            DP_INIT: begin
                nx_we = 1'b1; nx_wa = r_init; nx_wd = LINK_W'(r_init) + LINK_W'(1);
                pv_we = 1'b1; pv_wa = r_init;
                pv_wd = (r_init == '0) ? NIL : LINK_W'(r_init) - LINK_W'(1);
                us_we = 1'b1; us_wa = r_init; us_wd = 1'b0;
                n_init = r_init + SLOT_W'(1);
            end
            DP_ALLOC_RD: begin
                nx_re = 1'b1; nx_ra = r_free_head[SLOT_W-1:0];
                if (r_used_tail != NIL) begin
                    nx_we = 1'b1; nx_wa = r_used_tail[SLOT_W-1:0]; nx_wd = r_free_head;
                end
                pv_we = 1'b1; pv_wa = r_free_head[SLOT_W-1:0]; pv_wd = r_used_tail;
                us_we = 1'b1; us_wa = r_free_head[SLOT_W-1:0]; us_wd = 1'b1;
                n_slot = r_free_head[SLOT_W-1:0];
            end
            DP_ALLOC_WR: begin
                nx_we = 1'b1; nx_wa = r_slot; nx_wd = NIL;
                if (r_rd_next != NIL) begin
                    pv_we = 1'b1; pv_wa = r_rd_next[SLOT_W-1:0]; pv_wd = NIL;
                end else begin
                    n_free_tail = NIL;
                end
                n_free_head = r_rd_next;
                if (r_used_tail == NIL) begin
                    n_used_head = s_link;
                end
                n_used_tail = s_link;
            end
            DP_FREE_RD: begin
                nx_re = 1'b1; nx_ra = slot_idx;
                fr_re = 1'b1;
                n_slot = slot_idx;
            end
            DP_FREE_UNLINK: begin
                if (r_rd_prev != NIL) begin
                    nx_we = 1'b1; nx_wa = r_rd_prev[SLOT_W-1:0]; nx_wd = r_rd_next;
                end else begin
                    n_used_head = r_rd_next;
                end
                if (r_rd_next != NIL) begin
                    pv_we = 1'b1; pv_wa = r_rd_next[SLOT_W-1:0]; pv_wd = r_rd_prev;
                end else begin
                    n_used_tail = r_rd_prev;
                end
                us_we = 1'b1; us_wa = r_slot; us_wd = 1'b0;
            end
            DP_FREE_LINK1: begin
                pv_we = 1'b1; pv_wa = r_slot; pv_wd = r_free_tail;
                if (r_free_tail != NIL) begin
                    nx_we = 1'b1; nx_wa = r_free_tail[SLOT_W-1:0]; nx_wd = s_link;
                end else begin
                    n_free_head = s_link;
                end
            end
            DP_FREE_LINK2: begin
                nx_we = 1'b1; nx_wa = r_slot; nx_wd = NIL;
                n_free_tail = s_link;
            end
            DP_WALK_HEAD: begin
                nx_re = 1'b1; nx_ra = r_used_head[SLOT_W-1:0];
                us_we = 1'b1; us_wa = r_used_head[SLOT_W-1:0]; us_wd = 1'b0;
            end
            DP_WALK: begin
                nx_re = 1'b1; nx_ra = r_rd_next[SLOT_W-1:0];
                us_we = 1'b1; us_wa = r_rd_next[SLOT_W-1:0]; us_wd = 1'b0;
            end
            DP_SPLICE: begin
                nx_we = 1'b1; nx_wa = r_used_tail[SLOT_W-1:0]; nx_wd = r_free_head;
                if (r_free_head != NIL) begin
                    pv_we = 1'b1; pv_wa = r_free_head[SLOT_W-1:0]; pv_wd = r_used_tail;
                end else begin
                    n_free_tail = r_used_tail;
                end
                n_free_head = r_used_head;
                n_used_head = NIL;
                n_used_tail = NIL;
            end
            default: begin
            end
        endcase
    end

    // Link memories: one write and one registered read per cycle each
    always_ff @(posedge i_clk) begin
        if (nx_we) begin
            r_next_mem[nx_wa] <= nx_wd;
        end
        if (nx_re) begin
            r_rd_next <= r_next_mem[nx_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (pv_we) begin
            r_prev_mem[pv_wa] <= pv_wd;
        end
        if (fr_re) begin
            r_rd_prev <= r_prev_mem[slot_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (us_we) begin
            r_use_mem[us_wa] <= us_wd;
        end
        if (fr_re) begin
            r_rd_use <= r_use_mem[slot_idx];
        end
    end

    always_comb begin
        n_result.slot_out = i_cmd.grant ? t_slot_handle'(r_slot) : '0;
        n_result.status   = i_cmd.code;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free_head <= '0;
            r_free_tail <= LINK_W'(LAST);
            r_used_head <= NIL;
            r_used_tail <= NIL;
            r_init      <= '0;
            r_done      <= 1'b0;
        end else begin
            r_free_head <= n_free_head;
            r_free_tail <= n_free_tail;
            r_used_head <= n_used_head;
            r_used_tail <= n_used_tail;
            r_init      <= n_init;
            r_done      <= i_cmd.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
        if (i_cmd.emit) begin
            r_result <= n_result;
        end
    end

    always_comb begin
        o_status.init_last  = (r_init == LAST);
        o_status.free_empty = (r_free_head == NIL);
        o_status.used_empty = (r_used_head == NIL);
        o_status.slot_ok    = (32'(i_req.slot_in) < 32'(POOL_SLOTS));
        o_status.rd_in_use  = r_rd_use;
        o_status.walk_end   = (r_rd_next == NIL);
    end

    assign o_result = r_result;
    assign o_done   = r_done;

endmodule

### sv/fls_ctrl.sv
// Request sequencer of the free list slot allocator.
module fls_ctrl
    import fls_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  t_req_beat  i_req,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd,
    output logic       o_busy
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd.op    = DP_NONE;
        o_cmd.emit  = 1'b0;
        o_cmd.grant = 1'b0;
        o_cmd.code  = STATUS_OK;
        o_busy      = (r_state != ST_IDLE);
        case (r_state)
            ST_INIT: begin
                o_cmd.op = DP_INIT;
                if (i_status.init_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_start) begin
                    case (i_req.req_type)
                        REQ_ALLOC: begin
                            if (i_status.free_empty) begin
                                o_cmd.emit = 1'b1;
                                o_cmd.code = STATUS_EMPTY;
                            end else begin
                                o_cmd.op = DP_ALLOC_RD;
                                n_state  = ST_ALLOC_WR;
                            end
                        end
                        REQ_FREE: begin
                            if (!i_status.slot_ok) begin
                                o_cmd.emit = 1'b1;
                                o_cmd.code = STATUS_BAD_FREE;
                            end else begin
                                o_cmd.op = DP_FREE_RD;
                                n_state  = ST_FREE_CHK;
                            end
                        end
                        REQ_FREE_ALL: begin
                            if (i_status.used_empty) begin
                                o_cmd.emit = 1'b1;
                            end else begin
                                o_cmd.op = DP_WALK_HEAD;
                                n_state  = ST_WALK;
                            end
                        end
                        default: begin
                            o_cmd.emit = 1'b1;
                        end
                    endcase
                end
            end
            ST_ALLOC_WR: begin
                o_cmd.op    = DP_ALLOC_WR;
                o_cmd.emit  = 1'b1;
                o_cmd.grant = 1'b1;
                n_state     = ST_IDLE;
            end
            ST_FREE_CHK: begin
                if (!i_status.rd_in_use) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.code = STATUS_BAD_FREE;
                    n_state    = ST_IDLE;
                end else begin
                    o_cmd.op = DP_FREE_UNLINK;
                    n_state  = ST_FREE_LINK1;
                end
            end
            ST_FREE_LINK1: begin
                o_cmd.op = DP_FREE_LINK1;
                n_state  = ST_FREE_LINK2;
            end
            ST_FREE_LINK2: begin
                o_cmd.op   = DP_FREE_LINK2;
                o_cmd.emit = 1'b1;
                n_state    = ST_IDLE;
            end
            ST_WALK: begin
                if (i_status.walk_end) begin
                    o_cmd.op   = DP_SPLICE;
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end else begin
                    o_cmd.op = DP_WALK;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

### sv/free_list_slot_allocator.sv
// Top level of the free list slot allocator: sequencer plus link datapath.
//
// Keeps POOL_SLOTS slot handles on two doubly linked lists (free and used) held in
// three single-port-write memories (next link, prev link, in-use bit). A request
// beat is taken at a rising edge where start is high and busy is low; exactly one
// result beat follows, shown on o_result for one cycle with o_done high. The
// receiver cannot stall, so capture every o_done cycle. After reset the block
// runs a clearing pass over all POOL_SLOTS slots that builds the ascending free
// chain; busy stays high until it ends. Steps per request, from the accepting
// cycle (busy is high in all of them but that first one) and set by the link
// memory traffic (one registered read and one write per memory per cycle):
//   allocate: read free head's link, then relink; empty pool: answered at once
//   free: read links, unlink from used, then append to free (link, close tail)
//         out-of-range slot: answered at once, slot not in use: after the read
//   free-all: the walk clears one in-use bit per cycle over the used slots
//         and splices on the last step; nothing used: answered at once
//   unknown request: answered at once
// The result beat appears in the cycle after the last step, in which a new
// request may already be accepted.
module free_list_slot_allocator
    import fls_pkg::*;
#(
    parameter int POOL_SLOTS = FLS_POOL_SLOTS
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         start,
    output logic         busy,
    input  t_req_beat    i_req,
    output t_result_beat o_result,
    output logic         o_done
);

    t_dp_cmd    cmd;
    t_dp_status dp_status;
    logic       fail_beat;

    // Sequencer: decode the beat and step the datapath through each operation
    fls_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_req    (i_req),
        .i_status (dp_status),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    // Datapath: link memories, list pointers, registered result
    fls_datapath #(
        .POOL_SLOTS (POOL_SLOTS)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (i_req),
        .i_cmd    (cmd),
        .o_status (dp_status),
        .o_result (o_result),
        .o_done   (o_done)
    );

    // Result beat that reports a refused request
    assign fail_beat = o_done && (o_result.status != STATUS_OK);

`include "free_list_slot_allocator_assert.svh"

    // Every result is issued as the operation finishes, so busy is already low
    `FLS_ASSERT_NOW(a_done_when_idle, i_clk, i_rst_n, o_done, !busy)

    // An accepted beat either starts a multi-cycle operation or answers at once
    `FLS_ASSERT_NEXT(a_accept_progress, i_clk, i_rst_n, start && !busy, busy || o_done)

    // Only a granted allocate carries a nonzero slot
    `FLS_ASSERT_NOW(a_slot_zero_on_fail, i_clk, i_rst_n, fail_beat, o_result.slot_out == '0)

endmodule
